// File: design/lpft_pkg.sv
// ----------------------------------------------------------------------------
// lpft_pkg
// Shared types and constants for the LRU page fault tracker.
// ----------------------------------------------------------------------------
package lpft_pkg;

  localparam int PAGE_W = 16;
  localparam int CNT_W  = 16;
  localparam int CAP_W  = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
  localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};

  typedef struct packed {
    logic [PAGE_W-1:0] page;
    logic              first;
    logic              last;
  } req_t;

  typedef struct packed {
    logic             fault;
    logic [CNT_W-1:0] fault_total;
    logic             done_res;
  } res_t;

  typedef struct packed {
    logic load;
    logic look;
    logic upd;
  } cmd_t;

endpackage

// File: design/lru_page_fault_tracker.sv
// ----------------------------------------------------------------------------
// lru_page_fault_tracker
// Fully associative LRU page store with configurable capacity; reports hit or
// fault and a saturating fault total for every page request.
// ----------------------------------------------------------------------------
//  channel   ports                  handshake
//  request   req                    taken when start high and busy low
//  result    res                    valid for the one cycle done is high
//  config    cfg_data               written when cfg_we high
//
//  Each request goes through accept, tag lookup and store update; the result
//  appears in the cycle after the update, and busy falls in that cycle.
//  The tag compare over all slots and the rank update set the step split.
//  Synchronous reset empties the store, zeroes the total, sets capacity 16.
//  The receiver cannot stall; done is never held.
// ----------------------------------------------------------------------------
module lru_page_fault_tracker #(
  parameter int SLOTS     = 16,
  parameter int PAGE_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  lpft_pkg::req_t             req,
  input  logic                       cfg_we,
  input  logic [lpft_pkg::CAP_W-1:0] cfg_data,
  output logic                       done,
  output lpft_pkg::res_t             res
);
  import lpft_pkg::*;

  cmd_t cmd;

  lpft_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  lpft_dpath #(
    .SLOTS     (SLOTS),
    .PAGE_BITS (PAGE_BITS)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .req      (req),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .done     (done),
    .res      (res)
  );

endmodule

// File: design/lpft_ctrl.sv
// ----------------------------------------------------------------------------
// lpft_ctrl
// Sequencer: takes a request, then steps the datapath through lookup and
// update.
// ----------------------------------------------------------------------------
module lpft_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  output lpft_pkg::cmd_t cmd
);
  import lpft_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOOK = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) state_next = S_LOOK;
      end
      S_LOOK:  state_next = S_UPD;
      S_UPD:   state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy     = (state != S_IDLE);
  assign cmd.load = (state == S_IDLE) && start;
  assign cmd.look = (state == S_LOOK);
  assign cmd.upd  = (state == S_UPD);

endmodule

// File: design/lpft_dpath.sv
// ----------------------------------------------------------------------------
// lpft_dpath
// Slot store with tags, valid bits and age ranks; capacity register, fault
// counter and result register.
// ----------------------------------------------------------------------------
module lpft_dpath #(
  parameter int SLOTS     = 16,
  parameter int PAGE_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  lpft_pkg::cmd_t              cmd,
  input  lpft_pkg::req_t              req,
  input  logic                        cfg_we,
  input  logic [lpft_pkg::CAP_W-1:0]  cfg_data,
  output logic                        done,
  output lpft_pkg::res_t              res
);
  import lpft_pkg::*;

  localparam int TW = (PAGE_BITS < PAGE_W) ? PAGE_BITS : PAGE_W;
  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int RW = IW;
  localparam int CW = $clog2(SLOTS + 1);
  localparam int EW = (CW > CAP_W) ? CW : CAP_W;

  logic [CAP_W-1:0] cap;
  req_t             req_q;
  logic             valid [SLOTS];
  logic [TW-1:0]    tag   [SLOTS];
  logic [RW-1:0]    rank  [SLOTS];
  logic [CW-1:0]    occ;
  logic [CNT_W-1:0] fcnt;

  logic             hit_q;
  logic             fill_q;
  logic [IW-1:0]    tgt_q;
  logic [CW-1:0]    limit_q;

  logic [EW-1:0]    cap_ext;
  logic [CW-1:0]    cap_eff;
  logic [TW-1:0]    tag_in;
  logic             hit_any;
  logic             free_any;
  logic [IW-1:0]    hit_idx;
  logic [IW-1:0]    free_idx;
  logic [IW-1:0]    vict_idx;
  logic [CW-1:0]    hit_rank;
  logic             fill;
  logic [CNT_W-1:0] fcnt_next;

  assign tag_in  = req_q.page[TW-1:0];
  assign cap_ext = EW'(cap);

  always_comb begin
    if (cap_ext == '0) begin
      cap_eff = CW'(1);
    end else if (cap_ext > EW'(SLOTS)) begin
      cap_eff = CW'(SLOTS);
    end else begin
      cap_eff = CW'(cap_ext);
    end
  end

  always_comb begin
    hit_any  = 1'b0;
    free_any = 1'b0;
    hit_idx  = '0;
    free_idx = '0;
    vict_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (valid[i] && (tag[i] == tag_in)) begin
        hit_any = 1'b1;
        hit_idx = IW'(i);
      end
      if (!valid[i]) begin
        free_any = 1'b1;
        free_idx = IW'(i);
      end
      if (valid[i] && (CW'(rank[i]) == occ - CW'(1))) begin
        vict_idx = IW'(i);
      end
    end
  end

  assign hit_rank  = CW'(rank[hit_idx]);
  assign fill      = !hit_any && free_any && (occ < cap_eff);
  assign fcnt_next = (fcnt == CNT_MAX) ? fcnt : fcnt + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= CAP_RESET;
    end else if (cfg_we) begin
      cap <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q <= req;
    end
    if (cmd.look) begin
      hit_q  <= hit_any;
      fill_q <= fill;
      if (hit_any) begin
        tgt_q   <= hit_idx;
        limit_q <= hit_rank;
      end else if (fill) begin
        tgt_q   <= free_idx;
        limit_q <= occ;
      end else begin
        tgt_q   <= vict_idx;
        limit_q <= occ - CW'(1);
      end
    end
    if (cmd.upd && !hit_q) begin
      tag[tgt_q] <= tag_in;
    end
    if (cmd.upd) begin
      res.fault       <= !hit_q;
      res.fault_total <= hit_q ? fcnt : fcnt_next;
      res.done_res    <= req_q.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        valid[i] <= 1'b0;
        rank[i]  <= '0;
      end
      occ  <= '0;
      fcnt <= '0;
      done <= 1'b0;
    end else begin
      done <= cmd.upd;
      if (cmd.load && req.first) begin
        for (int i = 0; i < SLOTS; i++) begin
          valid[i] <= 1'b0;
          rank[i]  <= '0;
        end
        occ  <= '0;
        fcnt <= '0;
      end
      if (cmd.upd) begin
        for (int i = 0; i < SLOTS; i++) begin
          if (IW'(i) == tgt_q) begin
            valid[i] <= 1'b1;
            rank[i]  <= '0;
          end else if (valid[i] && (CW'(rank[i]) < limit_q)) begin
            rank[i] <= rank[i] + RW'(1);
          end
        end
        if (fill_q) begin
          occ <= occ + CW'(1);
        end
        if (!hit_q) begin
          fcnt <= fcnt_next;
        end
      end
    end
  end

endmodule
